// ===== rtl/core/shelf_rect_allocator_top_defines.svh =====
// Assertion macros used by the shelf allocator checker.
`ifndef SHELF_RECT_ALLOCATOR_TOP_DEFINES_SVH
`define SHELF_RECT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Delayed implication, disabled while reset is asserted.
`define SRA_ASSERT_LATER2(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sra_pkg.sv =====
// Shared types and constants of the shelf rectangle allocator.
`default_nettype none
package sra_pkg;

    localparam int DIM_W   = 15;          // coordinate / size width
    localparam int SUM_W   = DIM_W + 1;   // padded sizes and sums
    localparam int ENTRY_W = 3 * DIM_W;   // {top, height, used}

    localparam logic [DIM_W-1:0] ATLAS_SIZE_RESET = 15'd1024;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DONE
    } sra_state_t;

    typedef struct packed {
        logic load;   // capture the request word
        logic prep;   // early checks, clear
        logic scan;   // shelf scan step
    } sra_cmd_t;

    typedef struct packed {
        logic quick;      // result settled during prep
        logic hit;        // checked shelf takes the rectangle
        logic exhausted;  // scan finished without a hit
    } sra_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/sra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sra_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic                  re,
    input  wire logic [AW-1:0]         raddr,
    output      logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/sra_ctrl.sv =====
// Sequencer of the shelf allocator: accept, prepare, scan, deliver.
`default_nettype none
module sra_ctrl
    import sra_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output      logic        s_ready,
    output      logic        m_valid,
    input  wire logic        m_ready,
    input  wire sra_status_t status,
    output      sra_cmd_t    cmd
);
    sra_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = status.quick ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                if (status.hit || status.exhausted) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_DONE: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/sra_datapath.sv =====
// Datapath of the shelf allocator: shelf table, counters, fit tests, result word.
`default_nettype none
module sra_datapath
    import sra_pkg::*;
#(
    parameter int MAX_SHELVES = 64,
    parameter int GUTTER      = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire sra_cmd_t         cmd,
    output      sra_status_t      status,
    input  wire logic             s_op,
    input  wire logic [DIM_W-1:0] s_rect_width,
    input  wire logic [DIM_W-1:0] s_rect_height,
    input  wire logic             cfg_we,
    input  wire logic [DIM_W-1:0] cfg_wdata,
    output      logic             m_placed,
    output      logic [DIM_W-1:0] m_slot_x,
    output      logic [DIM_W-1:0] m_slot_y
);
    localparam int CNT_W = $clog2(MAX_SHELVES + 1);
    localparam int IDX_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;

    // request word
    logic             op_reg;
    logic [DIM_W-1:0] w_reg, h_reg;
    // allocator state
    logic [DIM_W-1:0] atlas_reg, atlas_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DIM_W-1:0] nft_reg, nft_next;
    // scan pipeline
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    // result word
    logic             placed_reg, placed_next;
    logic [DIM_W-1:0] x_reg, x_next, y_reg, y_next;

    logic [SUM_W-1:0]   pw, ph, atlas_ext, used_sum, top_sum;
    logic [SUM_W:0]     ph_dbl;
    logic               reject, issue, fit, room;
    logic [ENTRY_W-1:0] rd_data, wr_data;
    logic [DIM_W-1:0]   rd_top, rd_height, rd_used;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;

    sra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SHELVES)
    ) u_shelf_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.scan && issue),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign {rd_top, rd_height, rd_used} = rd_data;

    assign pw        = {1'b0, w_reg} + SUM_W'(GUTTER);
    assign ph        = {1'b0, h_reg} + SUM_W'(GUTTER);
    assign ph_dbl    = {ph, 1'b0};
    assign atlas_ext = {1'b0, atlas_reg};
    assign used_sum  = {1'b0, rd_used} + pw;
    assign top_sum   = {1'b0, nft_reg} + ph;

    assign reject = (op_reg == OP_CLEAR) || (w_reg == '0) || (h_reg == '0)
                  || (pw > atlas_ext) || (ph > atlas_ext);
    assign issue  = rd_idx_reg < count_reg;
    assign fit    = chk_vld_reg && ({1'b0, rd_height} >= ph)
                  && ({2'b00, rd_height} <= ph_dbl) && (used_sum <= atlas_ext);
    assign room   = (count_reg != CNT_W'(MAX_SHELVES)) && (top_sum <= atlas_ext);

    assign status.quick     = reject;
    assign status.hit       = fit;
    assign status.exhausted = !chk_vld_reg && !issue;

    always_comb begin
        atlas_next   = atlas_reg;
        count_next   = count_reg;
        nft_next     = nft_reg;
        rd_idx_next  = rd_idx_reg;
        chk_vld_next = chk_vld_reg;
        chk_idx_next = chk_idx_reg;
        placed_next  = placed_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        wr_en        = 1'b0;
        wr_addr      = chk_idx_reg;
        wr_data      = {rd_top, rd_height, used_sum[DIM_W-1:0]};

        if (cfg_we) begin
            atlas_next = cfg_wdata;
        end

        if (cmd.prep) begin
            rd_idx_next  = '0;
            chk_vld_next = 1'b0;
            placed_next  = 1'b0;
            x_next       = '0;
            y_next       = '0;
            if (op_reg == OP_CLEAR) begin
                count_next = '0;
                nft_next   = '0;
            end
        end

        if (cmd.scan) begin
            // one read issued per cycle; data checked in the following cycle
            chk_vld_next = issue;
            chk_idx_next = rd_idx_reg[IDX_W-1:0];
            if (issue) begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
            if (fit) begin
                wr_en       = 1'b1;
                placed_next = 1'b1;
                x_next      = rd_used;
                y_next      = rd_top;
            end else if (status.exhausted && room) begin
                wr_en       = 1'b1;
                wr_addr     = count_reg[IDX_W-1:0];
                wr_data     = {nft_reg, ph[DIM_W-1:0], pw[DIM_W-1:0]};
                count_next  = count_reg + 1'b1;
                nft_next    = top_sum[DIM_W-1:0];
                placed_next = 1'b1;
                x_next      = '0;
                y_next      = nft_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atlas_reg   <= ATLAS_SIZE_RESET;
            count_reg   <= '0;
            nft_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end else begin
            atlas_reg   <= atlas_next;
            count_reg   <= count_next;
            nft_reg     <= nft_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_op;
            w_reg  <= s_rect_width;
            h_reg  <= s_rect_height;
        end
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        placed_reg  <= placed_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
    end

    assign m_placed = placed_reg;
    assign m_slot_x = x_reg;
    assign m_slot_y = y_reg;
endmodule
`default_nettype wire

// ===== rtl/core/shelf_rect_allocator_top.sv =====
// Top level of the shelf rectangle allocator.
// Shelf-packing allocator for a square atlas. Each input word is either an
// allocate request (op 0, width and height in texels, each padded by GUTTER)
// or a clear (op 1), and each gives exactly one result word: placed plus
// slot_x/slot_y, both zero when not placed. Allocation takes the first
// stored shelf whose height lies between the padded height and twice it and
// which still has horizontal room; otherwise a new shelf opens below the
// last one if the atlas and the MAX_SHELVES table allow it. One word is
// handled at a time: the next word is taken in the cycle after the result
// is taken. The scan reads one shelf entry per cycle from the single-read-port
// shelf RAM. There is no clearing pass after reset; table entries beyond the
// shelf count are never read. atlas_size is written through the cfg port,
// which is always ready; write it only while idle.
`default_nettype none
module shelf_rect_allocator_top
    import sra_pkg::*;
#(
    parameter int MAX_SHELVES = 64,
    parameter int GUTTER      = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration: atlas_size
    input  wire logic             cfg_valid,
    output      logic             cfg_ready,
    input  wire logic [DIM_W-1:0] cfg_wdata,
    // request words
    input  wire logic             s_valid,
    output      logic             s_ready,
    input  wire logic             s_op,
    input  wire logic [DIM_W-1:0] s_rect_width,
    input  wire logic [DIM_W-1:0] s_rect_height,
    // result words
    output      logic             m_valid,
    input  wire logic             m_ready,
    output      logic             m_placed,
    output      logic [DIM_W-1:0] m_slot_x,
    output      logic [DIM_W-1:0] m_slot_y
);
    sra_cmd_t    cmd;
    sra_status_t status;

    // register write lands in the next cycle, never stalls
    assign cfg_ready = 1'b1;

    sra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sra_datapath #(
        .MAX_SHELVES (MAX_SHELVES),
        .GUTTER      (GUTTER)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_op          (s_op),
        .s_rect_width  (s_rect_width),
        .s_rect_height (s_rect_height),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_wdata     (cfg_wdata),
        .m_placed      (m_placed),
        .m_slot_x      (m_slot_x),
        .m_slot_y      (m_slot_y)
    );
endmodule
`default_nettype wire

// ===== rtl/core/sra_checker.sv =====
// Port-level assertions for the shelf allocator, bound to the top level.
`default_nettype none
`include "shelf_rect_allocator_top_defines.svh"
module sra_checker
    import sra_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire logic             s_op,
    input wire logic [DIM_W-1:0] s_rect_width,
    input wire logic [DIM_W-1:0] s_rect_height,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic             m_placed,
    input wire logic [DIM_W-1:0] m_slot_x,
    input wire logic [DIM_W-1:0] m_slot_y
);
    // one word in flight: never ready for input while a result is pending
    `SRA_ASSERT_SAME(a_one_in_flight, aclk, aresetn, 1'b1, !(s_ready && m_valid), "input ready while result pending")

    // a failed or clear result carries zero coordinates
    `SRA_ASSERT_SAME(a_zero_on_fail, aclk, aresetn, m_valid && !m_placed, (m_slot_x == '0) && (m_slot_y == '0), "nonzero slot on failure")

    // clear and zero-sized requests resolve early, unplaced
    `SRA_ASSERT_LATER2(a_early_reject, aclk, aresetn, s_valid && s_ready && ((s_op == OP_CLEAR) || (s_rect_width == '0) || (s_rect_height == '0)), m_valid && !m_placed, "early reject not delivered")

    // stalled result holds
    `SRA_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_placed) && $stable(m_slot_x) && $stable(m_slot_y), "stalled result changed")
endmodule

bind shelf_rect_allocator_top sra_checker u_sra_checker (.*);
`default_nettype wire
